// ===== rtl/eflf_pkg.sv =====
package eflf_pkg;

    // datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_SHIFT0,
        OP_CHECK,
        OP_ZERO_FLUX,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_MUL_T1,
        OP_MUL_RUU,
        OP_STEP_E,
        OP_MUL_P,
        OP_STEP_F,
        OP_MUL_F2,
        OP_COPY_FLUX,
        OP_SHIFT1,
        OP_UPD_SD,
        OP_UPD_MUL,
        OP_UPD_FIN,
        OP_EMIT,
        OP_SHIFT
    } dp_op_t;

    // source of an emitted item
    typedef enum logic [1:0] {
        SRC_CU,
        SRC_WNEW,
        SRC_NU
    } src_t;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DT_OVER_DX    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAMMA_MINUS_1 = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DENSITY_FLOOR = 2'd2;

    localparam int GAMMA_RESET = 26214;
    localparam int FLOOR_RESET = 1;

    localparam logic [1:0] COMP_LAST = 2'd2;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] comp;
        src_t       src;
        logic       end_flag;
        logic       err_flag;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/eflf_div.sv =====
module eflf_div
    import eflf_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic                done,
    output logic signed [W-1:0] quot
);

    localparam int N  = W + F;
    localparam int CW = $clog2(N + 1);
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic [N-1:0]  work_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    trial;
    logic          ge;
    logic [W:0]    diff;
    logic [W-1:0]  num_mag;
    logic          neg_q;
    logic [N-1:0]  lim;
    logic          over;

    assign num_mag = num[W-1] ? (~num + 1'b1) : num;
    assign trial   = {rem_reg, work_reg[N-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign diff    = trial - {1'b0, den_reg};

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= {num_mag, {F{1'b0}}};
            rem_reg  <= '0;
            den_reg  <= den;
            neg_reg  <= num[W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[N-2:0], ge};
            rem_reg  <= ge ? diff[W-1:0] : trial[W-1:0];
        end
    end

    // saturate the quotient to the signed word
    assign neg_q = neg_reg && (work_reg != '0);
    assign lim   = N'(SMAX) + N'(neg_q);
    assign over  = work_reg > lim;
    assign quot  = over ? (neg_q ? SMIN : SMAX)
                        : (neg_q ? -work_reg[W-1:0] : work_reg[W-1:0]);
    assign done  = done_reg;

endmodule

// ===== rtl/eflf_dp.sv =====
module eflf_dp
    import eflf_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic signed [W-1:0]       mass,
    input  logic signed [W-1:0]       momentum,
    input  logic signed [W-1:0]       energy,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [W-1:0]              cfg_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [W-1:0]       new_mass,
    output logic signed [W-1:0]       new_momentum,
    output logic signed [W-1:0]       new_energy,
    output logic                      density_error,
    output logic                      end_of_grid
);

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            sadd = s[W] ? SMIN : SMAX;
        else
            sadd = s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            ssub = s[W] ? SMIN : SMAX;
        else
            ssub = s[W-1:0];
    endfunction

    // halve, rounding toward zero
    function automatic logic signed [W-1:0] half(input logic signed [W-1:0] x);
        logic signed [W-1:0] xs;
        xs = x + {{(W-1){1'b0}}, x[W-1]};
        half = xs >>> 1;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        mag = x[W-1] ? (~x + 1'b1) : x;
    endfunction

    logic [W-1:0] dt_reg;
    logic [W-1:0] gamma_reg;
    logic [W-1:0] floor_reg;

    logic signed [W-1:0] cu_reg     [0:2];
    logic signed [W-1:0] cf_reg     [0:2];
    logic signed [W-1:0] nu_reg     [0:2];
    logic signed [W-1:0] wc_old_reg [0:2];
    logic signed [W-1:0] wc_new_reg [0:2];
    logic signed [W-1:0] wf_old_reg [0:2];
    logic signed [W-1:0] wf_new_reg [0:2];
    logic signed [W-1:0] vel_reg;
    logic signed [W-1:0] t1_reg;
    logic signed [W-1:0] ruu_reg;
    logic signed [W-1:0] p_reg;
    logic signed [W-1:0] acc_reg;
    logic signed [W-1:0] s_reg;
    logic signed [W-1:0] d_reg;
    logic signed [W-1:0] t_reg;
    logic                out_valid_reg;

    logic                div_done;
    logic signed [W-1:0] div_quot;
    logic                out_free;

    // shared multiplier
    logic signed [W-1:0] mul_a;
    logic [W-1:0]        mul_b;
    logic                mul_nb;
    logic                mul_sh1;
    logic [W-1:0]        mul_ma;
    logic [2*W-1:0]      prod;
    logic [2*W-1:0]      shifted;
    logic                mul_neg;
    logic                mul_over;
    logic signed [W-1:0] mul_res;

    eflf_div #(.W(W), .F(F)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .num   (cu_reg[1]),
        .den   (cu_reg[0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_nb  = 1'b0;
        mul_sh1 = 1'b0;
        unique case (cmd.op)
            OP_MUL_T1:
            begin
                mul_a  = cu_reg[0];
                mul_b  = mag(vel_reg);
                mul_nb = vel_reg[W-1];
            end
            OP_MUL_RUU:
            begin
                mul_a  = t1_reg;
                mul_b  = mag(vel_reg);
                mul_nb = vel_reg[W-1];
            end
            OP_MUL_P:
            begin
                mul_a = acc_reg;
                mul_b = gamma_reg;
            end
            OP_MUL_F2:
            begin
                mul_a  = acc_reg;
                mul_b  = mag(vel_reg);
                mul_nb = vel_reg[W-1];
            end
            OP_UPD_MUL:
            begin
                mul_a   = d_reg;
                mul_b   = dt_reg;
                mul_sh1 = 1'b1;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_ma   = mag(mul_a);
    assign prod     = {{W{1'b0}}, mul_ma} * {{W{1'b0}}, mul_b};
    assign shifted  = mul_sh1 ? (prod >> (F + 1)) : (prod >> F);
    assign mul_neg  = (mul_a[W-1] ^ mul_nb) && (shifted != '0);
    assign mul_over = shifted > (LIM_POS + {{(2*W-1){1'b0}}, mul_neg});
    assign mul_res  = mul_over ? (mul_neg ? SMIN : SMAX)
                               : (mul_neg ? -shifted[W-1:0] : shifted[W-1:0]);

    assign out_free = !out_valid_reg || !out_stall;

    assign status.bad = cu_reg[0][W-1] || (cu_reg[0] == '0)
                        || (cu_reg[0] < floor_reg);
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg        <= '0;
            gamma_reg     <= W'(GAMMA_RESET);
            floor_reg     <= W'(FLOOR_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DT_OVER_DX:    dt_reg    <= cfg_data;
                    CFG_GAMMA_MINUS_1: gamma_reg <= cfg_data;
                    CFG_DENSITY_FLOOR: floor_reg <= cfg_data;
                    default:           dt_reg    <= dt_reg;
                endcase
            end
            if (cmd.op == OP_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cu_reg[0] <= mass;
            cu_reg[1] <= momentum;
            cu_reg[2] <= energy;
        end
        if (div_done)
            vel_reg <= div_quot;
        unique case (cmd.op)
            OP_SHIFT0:
            begin
                for (int i = 0; i < 3; i++)
                    wc_new_reg[i] <= cu_reg[i];
            end
            OP_ZERO_FLUX:
            begin
                for (int i = 0; i < 3; i++)
                    cf_reg[i] <= '0;
            end
            OP_MUL_T1:  t1_reg  <= mul_res;
            OP_MUL_RUU: ruu_reg <= mul_res;
            OP_STEP_E:  acc_reg <= ssub(cu_reg[2], half(ruu_reg));
            OP_MUL_P:   p_reg   <= mul_res;
            OP_STEP_F:
            begin
                cf_reg[1] <= sadd(p_reg, ruu_reg);
                acc_reg   <= sadd(cu_reg[2], p_reg);
            end
            OP_MUL_F2:
            begin
                cf_reg[0] <= cu_reg[1];
                cf_reg[2] <= mul_res;
            end
            OP_COPY_FLUX:
            begin
                for (int i = 0; i < 3; i++)
                    cf_reg[i] <= wf_new_reg[i];
            end
            OP_SHIFT1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    wc_old_reg[i] <= wc_new_reg[i];
                    wf_old_reg[i] <= cf_reg[i];
                    wc_new_reg[i] <= cu_reg[i];
                    wf_new_reg[i] <= cf_reg[i];
                end
            end
            OP_UPD_SD:
            begin
                s_reg <= sadd(wc_old_reg[cmd.comp], cu_reg[cmd.comp]);
                d_reg <= ssub(cf_reg[cmd.comp], wf_old_reg[cmd.comp]);
            end
            OP_UPD_MUL: t_reg <= mul_res;
            OP_UPD_FIN: nu_reg[cmd.comp] <= ssub(half(s_reg), t_reg);
            OP_EMIT:
            begin
                if (out_free)
                begin
                    unique case (cmd.src)
                        SRC_CU:
                        begin
                            new_mass     <= cu_reg[0];
                            new_momentum <= cu_reg[1];
                            new_energy   <= cu_reg[2];
                        end
                        SRC_WNEW:
                        begin
                            new_mass     <= wc_new_reg[0];
                            new_momentum <= wc_new_reg[1];
                            new_energy   <= wc_new_reg[2];
                        end
                        default:
                        begin
                            new_mass     <= nu_reg[0];
                            new_momentum <= nu_reg[1];
                            new_energy   <= nu_reg[2];
                        end
                    endcase
                    density_error <= cmd.err_flag;
                    end_of_grid   <= cmd.end_flag;
                end
            end
            OP_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    wc_old_reg[i] <= wc_new_reg[i];
                    wf_old_reg[i] <= wf_new_reg[i];
                    wc_new_reg[i] <= cu_reg[i];
                    wf_new_reg[i] <= cf_reg[i];
                end
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/eflf_ctrl.sv =====
module eflf_ctrl
    import eflf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    last_node,
    input  status_t status,
    output logic    in_stall,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SHIFT0,
        S_CHECK,
        S_ZERO,
        S_DIV_START,
        S_DIV_WAIT,
        S_T1,
        S_RUU,
        S_E,
        S_P,
        S_F,
        S_F2,
        S_COPY,
        S_SHIFT1,
        S_U_SD,
        S_U_MUL,
        S_U_FIN,
        S_EMIT_A,
        S_EMIT_B,
        S_FIN
    } state_t;

    localparam logic [1:0] NS_EMPTY  = 2'd0;
    localparam logic [1:0] NS_FIRST  = 2'd1;
    localparam logic [1:0] NS_SECOND = 2'd2;
    localparam logic [1:0] NS_BEYOND = 2'd3;

    state_t     state_reg;
    logic [1:0] ns_reg;
    logic       last_reg;
    logic       err_reg;
    logic [1:0] comp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ns_reg    <= NS_EMPTY;
            last_reg  <= 1'b0;
            err_reg   <= 1'b0;
            comp_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= last_node;
                        priority if (ns_reg == NS_EMPTY)
                            state_reg <= last_node ? S_EMIT_A : S_SHIFT0;
                        else if (ns_reg == NS_FIRST)
                            state_reg <= last_node ? S_EMIT_A : S_CHECK;
                        else
                            state_reg <= last_node ? S_COPY : S_CHECK;
                    end
                end
                S_SHIFT0:
                begin
                    ns_reg    <= NS_FIRST;
                    state_reg <= S_IDLE;
                end
                S_CHECK:     state_reg <= status.bad ? S_ZERO : S_DIV_START;
                S_ZERO:
                begin
                    err_reg   <= 1'b1;
                    comp_reg  <= '0;
                    state_reg <= (ns_reg == NS_FIRST) ? S_SHIFT1 : S_U_SD;
                end
                S_DIV_START: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (status.div_done)
                        state_reg <= S_T1;
                end
                S_T1:        state_reg <= S_RUU;
                S_RUU:       state_reg <= S_E;
                S_E:         state_reg <= S_P;
                S_P:         state_reg <= S_F;
                S_F:         state_reg <= S_F2;
                S_F2:
                begin
                    comp_reg  <= '0;
                    state_reg <= (ns_reg == NS_FIRST) ? S_SHIFT1 : S_U_SD;
                end
                S_COPY:
                begin
                    comp_reg  <= '0;
                    state_reg <= S_U_SD;
                end
                S_SHIFT1:
                begin
                    ns_reg    <= NS_SECOND;
                    state_reg <= S_IDLE;
                end
                S_U_SD:      state_reg <= S_U_MUL;
                S_U_MUL:     state_reg <= S_U_FIN;
                S_U_FIN:
                begin
                    if (comp_reg == COMP_LAST)
                        state_reg <= S_EMIT_A;
                    else
                    begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= S_U_SD;
                    end
                end
                S_EMIT_A:
                begin
                    if (status.out_free)
                    begin
                        priority if (ns_reg == NS_EMPTY)
                            state_reg <= S_FIN;
                        else if (ns_reg == NS_FIRST || ns_reg == NS_SECOND || last_reg)
                            state_reg <= S_EMIT_B;
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_EMIT_B:
                begin
                    if (status.out_free)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (last_reg)
                    begin
                        ns_reg  <= NS_EMPTY;
                        err_reg <= 1'b0;
                    end
                    else
                        ns_reg <= NS_BEYOND;
                    state_reg <= S_IDLE;
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd.op       = OP_IDLE;
        cmd.comp     = comp_reg;
        cmd.src      = SRC_NU;
        cmd.end_flag = 1'b0;
        cmd.err_flag = err_reg;
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        unique case (state_reg)
            S_SHIFT0:    cmd.op = OP_SHIFT0;
            S_CHECK:     cmd.op = OP_CHECK;
            S_ZERO:      cmd.op = OP_ZERO_FLUX;
            S_DIV_START: cmd.op = OP_DIV_START;
            S_DIV_WAIT:  cmd.op = OP_DIV_WAIT;
            S_T1:        cmd.op = OP_MUL_T1;
            S_RUU:       cmd.op = OP_MUL_RUU;
            S_E:         cmd.op = OP_STEP_E;
            S_P:         cmd.op = OP_MUL_P;
            S_F:         cmd.op = OP_STEP_F;
            S_F2:        cmd.op = OP_MUL_F2;
            S_COPY:      cmd.op = OP_COPY_FLUX;
            S_SHIFT1:    cmd.op = OP_SHIFT1;
            S_U_SD:      cmd.op = OP_UPD_SD;
            S_U_MUL:     cmd.op = OP_UPD_MUL;
            S_U_FIN:     cmd.op = OP_UPD_FIN;
            S_EMIT_A:
            begin
                cmd.op = OP_EMIT;
                if (ns_reg == NS_EMPTY)
                    cmd.src = SRC_CU;
                else if (ns_reg == NS_FIRST)
                    cmd.src = SRC_WNEW;
                else
                    cmd.src = SRC_NU;
                cmd.end_flag = (ns_reg == NS_EMPTY);
            end
            S_EMIT_B:
            begin
                cmd.op       = OP_EMIT;
                cmd.src      = (ns_reg == NS_FIRST) ? SRC_CU : SRC_NU;
                cmd.end_flag = last_reg;
            end
            S_FIN:       cmd.op = last_reg ? OP_IDLE : OP_SHIFT;
            default:     cmd.op = OP_IDLE;
        endcase
    end

endmodule

// ===== rtl/euler_flux_lax_friedrichs_step.sv =====
// one node at a time: a node with a valid density passes the bit-serial divider and the
// shared multiplier, used up to seven times; the second node emits no item unless it ends
// the grid; bad-density and end-of-grid nodes skip the divider; some nodes emit a second
// item and output stalls hold the emit; rst_n async, active low: resets the window count
// to empty and clears the error flag
module euler_flux_lax_friedrichs_step
    import eflf_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    // node stream
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [WORD_BITS-1:0]  mass,
    input  logic signed [WORD_BITS-1:0]  momentum,
    input  logic signed [WORD_BITS-1:0]  energy,
    input  logic                         last_node,
    // updated node stream
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [WORD_BITS-1:0]  new_mass,
    output logic signed [WORD_BITS-1:0]  new_momentum,
    output logic signed [WORD_BITS-1:0]  new_energy,
    output logic                         density_error,
    output logic                         end_of_grid,
    // register writes
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [WORD_BITS-1:0]         cfg_data
);

    // controller steps through load, density check, division, the flux
    // products and the three-component update; datapath holds the window
    cmd_t    cmd;
    status_t status;

    eflf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_node (last_node),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // datapath: flux of the newest node, then the centred update of the
    // middle node, with the output register parting the item from the sink
    eflf_dp #(.W(WORD_BITS), .F(FRAC_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mass          (mass),
        .momentum      (momentum),
        .energy        (energy),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .new_mass      (new_mass),
        .new_momentum  (new_momentum),
        .new_energy    (new_energy),
        .density_error (density_error),
        .end_of_grid   (end_of_grid)
    );

    // an accepted item keeps the input closed for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after an item was taken");

    // the quotient is only ever produced while the controller waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (cmd.op == OP_DIV_WAIT))
        else $error("divider finished outside its wait step");

    // an emit with room in the output register shows an item next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT && status.out_free) |=> out_valid)
        else $error("emitted item missing at the output");

endmodule
